// ===== rtl/hsl_to_rgb_pixel_converter_unit_macros.svh =====
// ---------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Shared assertion forms, clocked on clk and disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef HSL_TO_RGB_PIXEL_CONVERTER_UNIT_MACROS_SVH
`define HSL_TO_RGB_PIXEL_CONVERTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define H2R_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsl to rgb converter check failed");

// Consequent must hold in the cycle after the antecedent.
`define H2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsl to rgb converter check failed");

`endif

// ===== rtl/h2r_pkg.sv =====
// ---------------------------------------------------------------------------
// HSL to RGB converter package
// Beat payload types, stage enable bundle and shared constants.
// ---------------------------------------------------------------------------
package h2r_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int HUE_W = 16;
  localparam int SL_W = 17;
  localparam int CH_W = 8;
  localparam logic [SL_W-1:0] IN_ONE = 17'h10000;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SL_W-1:0]  saturation;
    logic [SL_W-1:0]  lightness;
  } hsl_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic d;
    logic e;
  } stage_en_t;

endpackage

// ===== rtl/h2r_stream_if.sv =====
// ---------------------------------------------------------------------------
// HSL to RGB converter stream interface
// Valid/ready channel carrying one beat of a typed payload.
// ---------------------------------------------------------------------------
interface h2r_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/h2r_channel.sv =====
// ---------------------------------------------------------------------------
// HSL to RGB converter channel back end
// Evaluates the hue ramp for one channel and scales it to a byte.
// ---------------------------------------------------------------------------
module h2r_channel #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                       clk,
  input  h2r_pkg::stage_en_t         en,
  input  logic [FRAC_BITS+2:0]       t,
  input  logic [FRAC_BITS:0]         p,
  input  logic [FRAC_BITS:0]         d,
  output logic [h2r_pkg::CH_W-1:0]   value
);
  localparam int VW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 3;
  localparam int SW = VW + 9;
  localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] T1 = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] T3 = TW'(3) << FRAC_BITS;
  localparam logic [TW-1:0] T4 = TW'(4) << FRAC_BITS;

  logic [VW-1:0]   f;
  logic [2*VW-1:0] prod;
  logic [VW-1:0]   ramp;
  logic [VW-1:0]   p_d;
  logic [VW:0]     level;
  logic [SW-1:0]   scaled;
  logic [TW-1:0]   fall;

  always_comb begin
    fall = T4 - t;
    if (t < T1) begin
      f = t[VW-1:0];
    end else if (t < T3) begin
      f = ONE;
    end else if (t < T4) begin
      f = fall[VW-1:0];
    end else begin
      f = '0;
    end
    prod = d * f;
  end

  always_ff @(posedge clk) begin
    if (en.d) begin
      ramp <= prod[FRAC_BITS +: VW];
      p_d <= p;
    end
  end

  always_comb begin
    level = {1'b0, p_d} + {1'b0, ramp};
    scaled = {level, 8'b0} - SW'(level);
  end

  always_ff @(posedge clk) begin
    if (en.e) begin
      value <= scaled[FRAC_BITS +: h2r_pkg::CH_W];
    end
  end
endmodule

// ===== rtl/hsl_to_rgb_pixel_converter_unit.sv =====
// ---------------------------------------------------------------------------
// HSL to RGB pixel converter
// Converts one HSL pixel per beat to an 8-bit RGB triple.
// ---------------------------------------------------------------------------
// The converter takes one pixel every clock unless the output stalls, and
// holds five register stages: input scaling, the lightness-saturation
// product, the p/q and hue offset stage, the three ramp products, and the
// byte scaling that feeds the output. Each stage keeps its own valid bit,
// so a stalled output only stops the stages behind it and empty stages
// still fill. Grey pixels come out of the same path.
module hsl_to_rgb_pixel_converter_unit #(
  parameter int FRAC_BITS = h2r_pkg::FRAC_BITS_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  h2r_stream_if.sink   hsl,
  h2r_stream_if.source rgb
);
  localparam int VW = FRAC_BITS + 1;
  localparam int TW = FRAC_BITS + 3;
  localparam int HW = h2r_pkg::HUE_W + 3;
  localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam logic [VW-1:0] HALF = VW'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0] T2 = TW'(2) << FRAC_BITS;
  localparam logic [TW-1:0] T4 = TW'(4) << FRAC_BITS;
  localparam logic [TW-1:0] T6 = TW'(6) << FRAC_BITS;

  logic v_a, v_b, v_c, v_d, v_e;
  logic ready_a, ready_b, ready_c, ready_d, ready_e;
  h2r_pkg::stage_en_t en;

  logic [h2r_pkg::SL_W-1:0] sat_clip, light_clip;
  logic [HW-1:0]            hue6;
  logic [VW-1:0]            s_conv, l_conv;
  logic [TW-1:0]            t_conv;

  logic [VW-1:0]   s_a, l_a;
  logic [TW-1:0]   t6_a;
  logic [2*VW-1:0] ls_prod;
  logic [VW-1:0]   s_b, l_b, ls_b;
  logic [TW-1:0]   t6_b;

  logic [VW:0]     q_wide, p_wide;
  logic [VW-1:0]   q_val, p_val;
  logic [TW-1:0]   tr_sum, tr_val, tb_val;
  logic [VW-1:0]   p_c, d_c;
  logic [TW-1:0]   tr_c, tg_c, tb_c;

  always_comb begin
    ready_e = !v_e || rgb.ready;
    ready_d = !v_d || ready_e;
    ready_c = !v_c || ready_d;
    ready_b = !v_b || ready_c;
    ready_a = !v_a || ready_b;
    en.d = ready_d;
    en.e = ready_e;
  end

  assign hsl.ready = ready_a && !rst;
  assign rgb.valid = v_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else begin
      if (ready_a) v_a <= hsl.valid;
      if (ready_b) v_b <= v_a;
      if (ready_c) v_c <= v_b;
      if (ready_d) v_d <= v_c;
      if (ready_e) v_e <= v_d;
    end
  end

  always_comb begin
    sat_clip = (hsl.data.saturation > h2r_pkg::IN_ONE) ? h2r_pkg::IN_ONE
                                                        : hsl.data.saturation;
    light_clip = (hsl.data.lightness > h2r_pkg::IN_ONE) ? h2r_pkg::IN_ONE
                                                         : hsl.data.lightness;
    hue6 = HW'({hsl.data.hue, 2'b00}) + HW'({hsl.data.hue, 1'b0});
    if (FRAC_BITS >= 16) begin
      s_conv = VW'(sat_clip) << SH_L;
      l_conv = VW'(light_clip) << SH_L;
      t_conv = TW'(hue6) << SH_L;
    end else begin
      s_conv = VW'(sat_clip >> SH_R);
      l_conv = VW'(light_clip >> SH_R);
      t_conv = TW'(hue6 >> SH_R);
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      s_a <= s_conv;
      l_a <= l_conv;
      t6_a <= t_conv;
    end
  end

  assign ls_prod = l_a * s_a;

  always_ff @(posedge clk) begin
    if (ready_b) begin
      s_b <= s_a;
      l_b <= l_a;
      ls_b <= ls_prod[FRAC_BITS +: VW];
      t6_b <= t6_a;
    end
  end

  always_comb begin
    if (l_b < HALF) begin
      q_wide = {1'b0, l_b} + {1'b0, ls_b};
    end else begin
      q_wide = {1'b0, l_b} + {1'b0, s_b} - {1'b0, ls_b};
    end
    q_val = q_wide[VW-1:0];
    p_wide = {l_b, 1'b0} - {1'b0, q_val};
    p_val = p_wide[VW-1:0];
    tr_sum = t6_b + T2;
    tr_val = (tr_sum >= T6) ? tr_sum - T6 : tr_sum;
    tb_val = (t6_b < T2) ? t6_b + T4 : t6_b - T2;
  end

  always_ff @(posedge clk) begin
    if (ready_c) begin
      p_c <= p_val;
      d_c <= q_val - p_val;
      tr_c <= tr_val;
      tg_c <= t6_b;
      tb_c <= tb_val;
    end
  end

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk   (clk),
    .en    (en),
    .t     (tr_c),
    .p     (p_c),
    .d     (d_c),
    .value (rgb.data.red)
  );

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk   (clk),
    .en    (en),
    .t     (tg_c),
    .p     (p_c),
    .d     (d_c),
    .value (rgb.data.green)
  );

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk   (clk),
    .en    (en),
    .t     (tb_c),
    .p     (p_c),
    .d     (d_c),
    .value (rgb.data.blue)
  );
endmodule

// ===== rtl/h2r_checker.sv =====
// ---------------------------------------------------------------------------
// HSL to RGB converter port checker
// Watches the converter ports for stalls, latency and grey output.
// ---------------------------------------------------------------------------
`include "hsl_to_rgb_pixel_converter_unit_macros.svh"

module h2r_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     hsl_valid,
  input logic                     hsl_ready,
  input logic [h2r_pkg::SL_W-1:0] saturation,
  input logic                     rgb_valid,
  input logic                     rgb_ready,
  input logic [h2r_pkg::CH_W-1:0] red,
  input logic [h2r_pkg::CH_W-1:0] green,
  input logic [h2r_pkg::CH_W-1:0] blue
);
  logic [4:0] acc_hist;
  logic [4:0] grey_hist;
  logic [4:0] run_hist;

  // Five-bit histories of accepts, grey accepts and rgb_ready, bit 0 being the most recent.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_hist <= '0;
      grey_hist <= '0;
      run_hist <= '0;
    end else begin
      acc_hist <= {acc_hist[3:0], hsl_valid && hsl_ready};
      grey_hist <= {grey_hist[3:0], hsl_valid && hsl_ready && saturation == '0};
      run_hist <= {run_hist[3:0], rgb_ready};
    end
  end

  `H2R_ASSERT_NOW(a_ready_when_drained, rgb_ready, hsl_ready)
  `H2R_ASSERT_NEXT(a_stall_holds, rgb_valid && !rgb_ready,
                   rgb_valid && $stable(red) && $stable(green) && $stable(blue))
  `H2R_ASSERT_NOW(a_latency, acc_hist[4] && (&run_hist[3:0]), rgb_valid)
  `H2R_ASSERT_NOW(a_grey, grey_hist[4] && (&run_hist[3:0]), red == green && green == blue)
endmodule

bind hsl_to_rgb_pixel_converter_unit h2r_checker u_h2r_checker (
  .clk        (clk),
  .rst        (rst),
  .hsl_valid  (hsl.valid),
  .hsl_ready  (hsl.ready),
  .saturation (hsl.data.saturation),
  .rgb_valid  (rgb.valid),
  .rgb_ready  (rgb.ready),
  .red        (rgb.data.red),
  .green      (rgb.data.green),
  .blue       (rgb.data.blue)
);

// ===== tb/hsl_to_rgb_pixel_converter_unit_tb.sv =====
// ---------------------------------------------------------------------------
// HSL to RGB pixel converter testbench
// Streams directed and random pixels through the converter with random
// sender gaps and receiver stalls, and checks every RGB beat in order against
// a fixed-point conversion computed alongside the stimulus.
// ---------------------------------------------------------------------------
module hsl_to_rgb_pixel_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import h2r_pkg::*;

  localparam int FRAC = FRAC_BITS_DEFAULT;

  class rgb_ledger;
    rgb_t expected_rgb[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    function longint scale_in(longint v);
      return (FRAC >= 16) ? (v << (FRAC - 16)) : (v >> (16 - FRAC));
    endfunction

    function longint frac_mul(longint a, longint b);
      return (a * b) >> FRAC;
    endfunction

    function longint ramp_level(longint p, longint q, longint t);
      longint one;
      one = longint'(1) << FRAC;
      if (t < one) return p + frac_mul(q - p, t);
      if (t < 3 * one) return q;
      if (t < 4 * one) return p + frac_mul(q - p, 4 * one - t);
      return p;
    endfunction

    function logic [CH_W-1:0] to_byte(longint v);
      longint c;
      c = v;
      if (c < 0) c = 0;
      if (c > (longint'(1) << FRAC)) c = longint'(1) << FRAC;
      return CH_W'((c * 255) >> FRAC);
    endfunction

    function rgb_t convert_pixel(hsl_t px);
      longint one, s, l, q, p, t6, tr, tb;
      logic [CH_W-1:0] y;
      rgb_t res;
      one = longint'(1) << FRAC;
      s = scale_in((px.saturation > IN_ONE) ? IN_ONE : px.saturation);
      l = scale_in((px.lightness > IN_ONE) ? IN_ONE : px.lightness);
      if (s == 0) begin
        y = to_byte(l);
        res.red = y;
        res.green = y;
        res.blue = y;
        return res;
      end
      if (l < one / 2) q = l + frac_mul(l, s);
      else q = l + s - frac_mul(l, s);
      p = 2 * l - q;
      t6 = scale_in(6 * longint'(px.hue));
      tr = t6 + 2 * one;
      if (tr >= 6 * one) tr -= 6 * one;
      tb = t6 - 2 * one;
      if (tb < 0) tb += 6 * one;
      res.red = to_byte(ramp_level(p, q, tr));
      res.green = to_byte(ramp_level(p, q, t6));
      res.blue = to_byte(ramp_level(p, q, tb));
      return res;
    endfunction

    function void note_pixel(hsl_t px);
      expected_rgb.push_back(convert_pixel(px));
    endfunction

    function void check_rgb(rgb_t got);
      rgb_t want;
      if (expected_rgb.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected rgb beat: got %0d %0d %0d", got.red, got.green, got.blue);
        return;
      end
      want = expected_rgb.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
        failures++;
        if (failures <= 10)
          $display("rgb mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  h2r_stream_if #(.payload_t(hsl_t)) hsl ();
  h2r_stream_if #(.payload_t(rgb_t)) rgb ();

  hsl_to_rgb_pixel_converter_unit #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .hsl(hsl),
    .rgb(rgb)
  );

  rgb_ledger ledger = new();
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int burst_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function logic [SL_W-1:0] random_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return IN_ONE;
      2: return SL_W'($urandom_range(65537, 131071));
      3: return SL_W'($urandom_range(0, 255));
      4: return SL_W'($urandom_range(32760, 32776));
      default: return SL_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function hsl_t random_pixel();
    hsl_t px;
    if ($urandom_range(0, 3) == 0)
      px.hue = HUE_W'(($urandom_range(0, 5) * 65536) / 6 + $urandom_range(0, 6) - 3);
    else
      px.hue = HUE_W'($urandom_range(0, 65535));
    px.saturation = random_level();
    px.lightness = random_level();
    return px;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken,
  // or after the idle gap that follows it.
  task automatic push_pixel(input hsl_t px);
    hsl.valid <= 1'b1;
    hsl.data <= px;
    do @(posedge clk); while (hsl.ready !== 1'b1);
    ledger.note_pixel(px);
    if (!tx_steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        hsl.valid <= 1'b0;
        hsl.data <= random_pixel();
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  task automatic hold_until_drained();
    hsl.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int run_left;
    bit level;
    run_left = 0;
    level = 1'b1;
    rgb.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        level = ($urandom_range(0, 2) != 0);
        run_left = $urandom_range(1, 8);
      end
      run_left--;
      rgb.ready <= level || rx_steady;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && rgb.valid === 1'b1 && rgb.ready === 1'b1)
      ledger.check_rgb(rgb.data);
  end

  initial begin
    rst <= 1'b1;
    hsl.valid <= 1'b0;
    hsl.data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    push_pixel(hsl_t'{16'd0, 17'd0, 17'd0});
    push_pixel(hsl_t'{16'd0, 17'd0, 17'd32768});
    push_pixel(hsl_t'{16'd0, 17'd0, 17'd65536});
    push_pixel(hsl_t'{16'd65535, 17'd0, 17'd131071});
    push_pixel(hsl_t'{16'd0, 17'd65536, 17'd32768});
    push_pixel(hsl_t'{16'd10923, 17'd65536, 17'd32768});
    push_pixel(hsl_t'{16'd21845, 17'd65536, 17'd32768});
    push_pixel(hsl_t'{16'd32768, 17'd65536, 17'd32768});
    push_pixel(hsl_t'{16'd43691, 17'd65536, 17'd32768});
    push_pixel(hsl_t'{16'd54613, 17'd65536, 17'd32768});
    push_pixel(hsl_t'{16'd65535, 17'd65536, 17'd32768});
    push_pixel(hsl_t'{16'd0, 17'd65536, 17'd32767});
    push_pixel(hsl_t'{16'd21845, 17'd131071, 17'd32767});
    push_pixel(hsl_t'{16'd43690, 17'd32768, 17'd65535});
    push_pixel(hsl_t'{16'd5461, 17'd32768, 17'd131071});
    push_pixel(hsl_t'{16'h5555, 17'd1, 17'd1});
    push_pixel(hsl_t'{16'hAAAA, 17'd65535, 17'd49152});
    push_pixel(hsl_t'{16'd16384, 17'd98304, 17'd16384});
    push_pixel(hsl_t'{16'd60000, 17'd1, 17'd65536});
    push_pixel(hsl_t'{16'd10922, 17'd65536, 17'd0});
    push_pixel(hsl_t'{16'd32767, 17'd40000, 17'd20000});
    hold_until_drained();

    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (120) push_pixel(random_pixel());
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_until_drained();

    repeat (830) push_pixel(random_pixel());
    hold_until_drained();
    repeat (12) @(posedge clk);

    if (ledger.failures == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
